// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante; quiet while reset is asserted.
`define SCMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante; quiet while reset is asserted.
`define SCMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/scmp_pkg.sv =====
// Types and fixed-point constants of the sine/cosine polynomial evaluator.
package scmp_pkg;

	typedef logic signed [31:0] angle_t;
	typedef logic signed [31:0] result_t;

	// Horner accumulator, Q.32, raw range -2^33 to 2^33-1
	localparam int ACC_W = 34;
	typedef logic signed [ACC_W-1:0] acc_t;

	// 1/(2*pi), unsigned Q0.32
	localparam logic [31:0] INV_TWO_PI_Q32 = 32'h28BE60DC;

	// Range reduction constants, Q.44
	localparam logic signed [47:0] TWO_PI_Q44  = 48'sh6487ED5110B4;
	localparam logic signed [47:0] PI_Q44      = 48'sh3243F6A8885A;
	localparam logic signed [47:0] HALF_PI_Q44 = 48'sh1921FB54442D;

	// Sine polynomial in y^2, Q.32, highest order first
	localparam acc_t SIN_START = -34'sd103;
	localparam acc_t SIN_COEF [5] = '{
		34'sd11822, -34'sd852159, 34'sd35791384, -34'sd715827897, 34'sd4294967296
	};

	// Cosine polynomial in y^2, Q.32, highest order first
	localparam acc_t COS_START = -34'sd1119;
	localparam acc_t COS_COEF [5] = '{
		34'sd106346, -34'sd5965013, 34'sd178956848, -34'sd2147483648, 34'sd4294967296
	};

	typedef struct packed {
		logic [31:0]        y2;
		logic signed [31:0] y;
		logic               flip;
	} side_t;

endpackage

// ===== src/scmp_if.sv =====
// Valid/ready channel interfaces for angle and result beats.
interface scmp_angle_if import scmp_pkg::*; ();
	logic   valid;
	logic   ready;
	angle_t angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

interface scmp_result_if import scmp_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t sine;
	result_t cosine;

	modport source (output valid, output sine, output cosine, input ready);
	modport sink (input valid, input sine, input cosine, output ready);
endinterface

// ===== src/sine_cosine_minimax_polynomial.sv =====
// Top level: pipelined sine/cosine of a fixed-point angle by minimax polynomials.
// Twenty register stages; throughput is one beat per cycle while the sink is ready.
// Each stage holds one multiplier or a short add chain.
// A stalled result holds the full stages nearest the output; stages above a bubble keep
// advancing, so the input stalls only once all twenty stages are full.
// Reset clears the stage valid bits only; the data registers are not reset.
module sine_cosine_minimax_polynomial import scmp_pkg::*; #(
	parameter int ANGLE_FRAC_BITS  = 24,
	parameter int RESULT_FRAC_BITS = 30
) (
	input logic           clk,
	input logic           arst_n,
	scmp_angle_if.sink    arg,
	scmp_result_if.source res
);

	// Stage map:
	//   1      |angle| * 1/(2*pi)
	//   2      round the quotient, restore its sign
	//   3      quotient * 2*pi
	//   4      reduced angle in Q.44
	//   5      fold into [-pi/2, pi/2], note the cosine flip
	//   6      round to Q.30 (y)
	//   7      y * y
	//   8      round to Q.30 (y2)
	//   9..18  five Horner steps, each a multiply stage and a round/add stage
	//   19     sine product S*y, cosine rounding and flip
	//   20     sine rounding, clamp both outputs (output register)
	localparam int NS      = 20;
	localparam int SHA     = 44 - ANGLE_FRAC_BITS;
	localparam int QSH     = ANGLE_FRAC_BITS + 32;
	localparam int QW      = 31 - ANGLE_FRAC_BITS;
	localparam int MW      = QW + 48;
	localparam int PW      = ACC_W + 33;
	localparam int SYW     = ACC_W + 32;
	localparam int CW      = ACC_W + 1;
	localparam int SINE_SH = 62 - RESULT_FRAC_BITS;
	localparam int COS_SH  = 32 - RESULT_FRAC_BITS;

	localparam logic [63:0]           Q_HALF    = 64'd1 << (QSH - 1);
	localparam logic signed [47:0]    Y_HALF    = 48'sd1 <<< 13;
	localparam logic signed [63:0]    Y2_HALF   = 64'sd1 <<< 29;
	localparam logic signed [PW-1:0]  P_HALF    = PW'(64'sd1) <<< 29;
	localparam logic signed [SYW-1:0] SINE_HALF = SYW'(64'sd1) <<< (SINE_SH - 1);
	localparam logic signed [SYW-1:0] ONE_S     = SYW'(64'sd1) <<< RESULT_FRAC_BITS;
	localparam logic signed [CW-1:0]  COS_HALF  = CW'(64'sd1) <<< (COS_SH - 1);
	localparam logic signed [CW-1:0]  ONE_C     = CW'(64'sd1) <<< RESULT_FRAC_BITS;

	// Horner multiply: signed accumulator times unsigned y2
	function automatic logic signed [PW-1:0] mul_y2(acc_t acc, logic [31:0] y2);
		return PW'(acc) * PW'($signed({1'b0, y2}));
	endfunction

	// Horner add: round the product back to Q.32 and add the coefficient
	function automatic acc_t round_add(logic signed [PW-1:0] p, acc_t coef);
		logic signed [PW-1:0] r;
		r = (p + P_HALF) >>> 30;
		return acc_t'(r) + coef;
	endfunction

	// ------------------------------------------------------------------
	// Flow control: a stage advances when it is empty or everything
	// below it moves. Stage k stalls only if stages k..NS are all full
	// and the sink holds off.
	// ------------------------------------------------------------------
	logic [NS:1] vld_s;
	logic [NS:1] adv;

	for (genvar k = 1; k <= NS; k++) begin : g_adv
		assign adv[k] = res.ready | ~(&vld_s[NS:k]);
	end

	assign arg.ready = adv[1];
	assign res.valid = vld_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= arg.valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Range reduction
	// ------------------------------------------------------------------
	angle_t                 a_s1, a_s2, a_s3;
	logic [63:0]            prod_s1;
	logic signed [QW-1:0]   q_s2;
	logic signed [MW-1:0]   qm_s3;
	logic signed [47:0]     y44_s4;
	logic signed [47:0]     yf_s5;
	logic                   flip_s5, flip_s6, flip_s7;
	logic signed [31:0]     y_s6, y_s7;
	logic signed [63:0]     yy_s7;

	logic [31:0]            mag;
	logic [63:0]            qsum, qshift;
	logic [QW-1:0]          qmag;
	logic signed [QW-1:0]   q;
	logic signed [MW-1:0]   qm;
	logic signed [63:0]     y44;
	logic signed [47:0]     yf, yr;
	logic                   fold_flip;
	logic signed [63:0]     yy, y2r;

	always_comb begin
		// the most negative angle negates to 2^31, which still fits unsigned
		mag    = arg.angle[31] ? 32'(-arg.angle) : arg.angle;
		qsum   = prod_s1 + Q_HALF;
		qshift = qsum >> QSH;
		qmag   = qshift[QW-1:0];
		// magnitude rounding gives ties away from zero
		q      = a_s1[31] ? -$signed(qmag) : $signed(qmag);
		qm     = MW'(q_s2) * MW'(TWO_PI_Q44);
		y44    = (64'(a_s3) <<< SHA) - 64'(qm_s3);

		// fold only values strictly beyond +/- pi/2
		yf        = y44_s4;
		fold_flip = 1'b0;
		if (y44_s4 > HALF_PI_Q44) begin
			yf        = PI_Q44 - y44_s4;
			fold_flip = 1'b1;
		end else if (y44_s4 < -HALF_PI_Q44) begin
			yf        = -PI_Q44 - y44_s4;
			fold_flip = 1'b1;
		end

		yr  = (yf_s5 + Y_HALF) >>> 14;
		yy  = 64'(y_s6) * 64'(y_s6);
		y2r = (yy_s7 + Y2_HALF) >>> 30;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			a_s1    <= arg.angle;
			prod_s1 <= 64'(mag) * 64'(INV_TWO_PI_Q32);
		end
		if (adv[2]) begin
			a_s2 <= a_s1;
			q_s2 <= q;
		end
		if (adv[3]) begin
			a_s3  <= a_s2;
			qm_s3 <= qm;
		end
		if (adv[4]) begin
			y44_s4 <= y44[47:0];
		end
		if (adv[5]) begin
			yf_s5   <= yf;
			flip_s5 <= fold_flip;
		end
		if (adv[6]) begin
			y_s6    <= yr[31:0];
			flip_s6 <= flip_s5;
		end
		if (adv[7]) begin
			yy_s7   <= yy;
			y_s7    <= y_s6;
			flip_s7 <= flip_s6;
		end
	end

	// ------------------------------------------------------------------
	// Horner evaluation in y2, sine and cosine side by side.
	// side_s[k] carries y2, y and the cosine flip at stage k.
	// ------------------------------------------------------------------
	side_t                side_s [8:NS-2];
	logic signed [PW-1:0] sprod_s [5];
	logic signed [PW-1:0] cprod_s [5];
	acc_t                 sacc_s  [5];
	acc_t                 cacc_s  [5];

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			side_s[8].y2   <= y2r[31:0];
			side_s[8].y    <= y_s7;
			side_s[8].flip <= flip_s7;
		end
	end

	for (genvar j = 0; j < 5; j++) begin : g_horner
		acc_t sin_in, cos_in;

		if (j == 0) begin : g_first
			assign sin_in = SIN_START;
			assign cos_in = COS_START;
		end else begin : g_next
			assign sin_in = sacc_s[j-1];
			assign cos_in = cacc_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv[9+2*j]) begin
				sprod_s[j]      <= mul_y2(sin_in, side_s[8+2*j].y2);
				cprod_s[j]      <= mul_y2(cos_in, side_s[8+2*j].y2);
				side_s[9+2*j]   <= side_s[8+2*j];
			end
			if (adv[10+2*j]) begin
				sacc_s[j]       <= round_add(sprod_s[j], SIN_COEF[j]);
				cacc_s[j]       <= round_add(cprod_s[j], COS_COEF[j]);
				side_s[10+2*j]  <= side_s[9+2*j];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output scaling and saturation to +/- one
	// ------------------------------------------------------------------
	logic signed [SYW-1:0] sy_s19;
	logic signed [CW-1:0]  cos_s19;
	result_t               sine_s20, cos_s20;

	logic signed [SYW-1:0] sy, sr, sc;
	logic signed [CW-1:0]  cr, cn, cc;

	always_comb begin
		sy = SYW'(sacc_s[4]) * SYW'(side_s[NS-2].y);
		cr = (CW'(cacc_s[4]) + COS_HALF) >>> COS_SH;
		// flip after rounding, as the fold mirrors the cosine
		cn = side_s[NS-2].flip ? -cr : cr;

		sr = (sy_s19 + SINE_HALF) >>> SINE_SH;
		if (sr > ONE_S) begin
			sc = ONE_S;
		end else if (sr < -ONE_S) begin
			sc = -ONE_S;
		end else begin
			sc = sr;
		end

		if (cos_s19 > ONE_C) begin
			cc = ONE_C;
		end else if (cos_s19 < -ONE_C) begin
			cc = -ONE_C;
		end else begin
			cc = cos_s19;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			sy_s19  <= sy;
			cos_s19 <= cn;
		end
		if (adv[NS]) begin
			sine_s20 <= result_t'(sc);
			cos_s20  <= result_t'(cc);
		end
	end

	assign res.sine   = sine_s20;
	assign res.cosine = cos_s20;

endmodule

// ===== src/scmp_checker.sv =====
// Port-level checker for the sine/cosine evaluator, bound to the top level.
`include "assert_macros.svh"

module scmp_checker import scmp_pkg::*; #(
	parameter int RESULT_FRAC_BITS = 30
) (
	input logic    clk,
	input logic    arst_n,
	input logic    arg_valid,
	input logic    arg_ready,
	input logic    res_valid,
	input logic    res_ready,
	input result_t sine,
	input result_t cosine
);

	localparam result_t ONE = result_t'(64'sd1 <<< RESULT_FRAC_BITS);

	// an empty output stage means the whole pipeline can move
	`SCMP_ASSERT_NOW(a_ready_when_drained, !res_valid, arg_ready, "input stalled with no result pending")

	// a stalled result beat holds
	`SCMP_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(sine) && $stable(cosine), "stalled result beat changed")

	// saturation keeps both outputs within plus or minus one
	`SCMP_ASSERT_NOW(a_sine_range, res_valid, (sine <= ONE) && (sine >= -ONE), "sine beyond plus or minus one")
	`SCMP_ASSERT_NOW(a_cosine_range, res_valid, (cosine <= ONE) && (cosine >= -ONE), "cosine beyond plus or minus one")

endmodule

bind sine_cosine_minimax_polynomial scmp_checker #(
	.RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_scmp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.arg_valid (arg.valid),
	.arg_ready (arg.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.sine      (res.sine),
	.cosine    (res.cosine)
);

// ===== bench/sine_cosine_minimax_polynomial_checker.sv =====
// Checker for the sine/cosine evaluator: predicts each result beat and compares it.
module sine_cosine_minimax_polynomial_checker import scmp_pkg::*; #(
	parameter int ANGLE_FRAC_BITS  = 24,
	parameter int RESULT_FRAC_BITS = 30
) (
	input logic    clk,
	input logic    arst_n,
	scmp_angle_if  arg,
	scmp_result_if res,
	output int     mismatches,
	output int     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		angle_t  angle;
		result_t sine;
		result_t cosine;
	} sincos_t;

	sincos_t expected_sincos[$];
	int      mismatch_count = 0;

	assign mismatches = mismatch_count;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Round to nearest, ties toward plus infinity.
	function automatic longint round_up_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_unit(input longint v);
		longint one;
		one = longint'(1) << RESULT_FRAC_BITS;
		if (v > one)
			return one;
		if (v < -one)
			return -one;
		return v;
	endfunction

	function automatic sincos_t predict_sincos(input angle_t angle);
		sincos_t     p;
		longint      a, q, y44, y, y2, s_acc, c_acc, cs;
		logic [63:0] mag, qmag;
		logic        flip;
		a = longint'(angle);
		mag = (a < 0) ? 64'(-a) : 64'(a);
		qmag = (mag * 64'(INV_TWO_PI_Q32) + (64'd1 << (ANGLE_FRAC_BITS + 31)))
			>> (ANGLE_FRAC_BITS + 32);
		q = longint'(qmag);
		if (a < 0)
			q = -q;
		y44 = a * (longint'(1) << (44 - ANGLE_FRAC_BITS)) - q * longint'(TWO_PI_Q44);
		flip = 1'b0;
		if (y44 > longint'(HALF_PI_Q44)) begin
			y44 = longint'(PI_Q44) - y44;
			flip = 1'b1;
		end else if (y44 < -longint'(HALF_PI_Q44)) begin
			y44 = -longint'(PI_Q44) - y44;
			flip = 1'b1;
		end
		y = round_up_shift(y44, 14);
		y2 = round_up_shift(y * y, 30);
		s_acc = longint'(SIN_START);
		c_acc = longint'(COS_START);
		for (int i = 0; i < 5; i++) begin
			s_acc = round_up_shift(s_acc * y2, 30) + longint'(SIN_COEF[i]);
			c_acc = round_up_shift(c_acc * y2, 30) + longint'(COS_COEF[i]);
		end
		cs = round_up_shift(c_acc, 32 - RESULT_FRAC_BITS);
		if (flip)
			cs = -cs;
		p.angle = angle;
		p.sine = result_t'(clamp_unit(round_up_shift(s_acc * y, 62 - RESULT_FRAC_BITS)));
		p.cosine = result_t'(clamp_unit(cs));
		return p;
	endfunction

	always @(posedge clk) begin
		sincos_t want;
		if (arst_n) begin
			// Retire a result beat first; an angle taken at this edge cannot be its source.
			if (res.valid && res.ready) begin
				if (expected_sincos.size() == 0) begin
					report_mismatch($sformatf("result beat sine %0d cosine %0d with none expected",
						res.sine, res.cosine));
				end else begin
					want = expected_sincos.pop_front();
					if (res.sine !== want.sine)
						report_mismatch($sformatf("angle %0d: sine %0d, expected %0d",
							want.angle, res.sine, want.sine));
					if (res.cosine !== want.cosine)
						report_mismatch($sformatf("angle %0d: cosine %0d, expected %0d",
							want.angle, res.cosine, want.cosine));
				end
			end
			if (arg.valid && arg.ready)
				expected_sincos.push_back(predict_sincos(arg.angle));
			pending <= expected_sincos.size();
		end
	end

endmodule

// ===== bench/sine_cosine_minimax_polynomial_test.sv =====
// Top of the sine/cosine evaluator testbench: clock, reset, angle stimulus, verdict.
module sine_cosine_minimax_polynomial_test import scmp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANGLE_FRAC_BITS  = 24;
	localparam int RESULT_FRAC_BITS = 30;
	// Pipeline depth is 20; give the drain plenty of slack.
	localparam int DRAIN_CYCLES     = 40;
	// ~800 beats, each at worst an idle gap plus a stall, plus pauses.
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int RANDOM_BLOCKS    = 5;
	localparam int BLOCK_BEATS      = 150;

	logic        clk;
	logic        arst_n;
	int          mismatches;
	int          pending;
	int unsigned cycle_count = 0;
	bit          sender_idles = 1'b0;
	bit          receiver_idles = 1'b0;
	int          stall_left = 0;

	scmp_angle_if  arg_ch ();
	scmp_result_if res_ch ();

	sine_cosine_minimax_polynomial #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.RESULT_FRAC_BITS(RESULT_FRAC_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.arg   (arg_ch),
		.res   (res_ch)
	);

	sine_cosine_minimax_polynomial_checker #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.RESULT_FRAC_BITS(RESULT_FRAC_BITS)
	) checker_inst (
		.clk       (clk),
		.arst_n    (arst_n),
		.arg       (arg_ch),
		.res       (res_ch),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung pipeline or a lost beat ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Angle k * pi/2 in the input format, nudged by a few LSBs. Even k lands on
	// multiples of pi, and k = 2 * odd sits on a quotient tie (odd multiple of pi).
	function automatic angle_t near_half_pi(input int k, input int nudge);
		return angle_t'(((longint'(k) * longint'(HALF_PI_Q44)) >>> (44 - ANGLE_FRAC_BITS))
			+ nudge);
	endfunction

	// Result side: drop ready in random bursts while allowed.
	// Change ready only at the falling edge so the rising edge sees a settled value.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 13);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one angle beat and hold it until taken. Enter and leave at a falling
	// edge; valid stays high on exit so back-to-back beats leave no gap.
	task automatic send_angle(input angle_t a);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			arg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		arg_ch.valid <= 1'b1;
		arg_ch.angle <= a;
		do @(posedge clk); while (!arg_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic drain_results();
		arg_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		angle_t directed[$];
		angle_t a;
		int     m;
		arst_n = 1'b0;
		arg_ch.valid = 1'b0;
		arg_ch.angle = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed beats: field extremes, fold bounds at +/- pi/2, pi itself,
		// quotient ties at odd multiples of pi, and whole turns.
		directed = '{
			angle_t'(0), angle_t'(1), angle_t'(-1),
			angle_t'(32'h7FFF_FFFF), angle_t'(32'h8000_0000),
			near_half_pi(1, 0), near_half_pi(1, 1), near_half_pi(1, -1),
			near_half_pi(-1, 0), near_half_pi(-1, 1), near_half_pi(-1, -1),
			near_half_pi(2, 0), near_half_pi(2, 1), near_half_pi(-2, 0),
			near_half_pi(3, 0), near_half_pi(4, 0),
			near_half_pi(6, 0), near_half_pi(6, 1), near_half_pi(-6, 0),
			near_half_pi(-6, -1), near_half_pi(78, 0), near_half_pi(-78, 1)
		};
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		foreach (directed[i])
			send_angle(directed[i]);
		drain_results();

		// Random beats in blocks that vary who idles; the last block runs flat out.
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			sender_idles = (b == 0 || b == 2);
			receiver_idles = (b == 0 || b == 3);
			for (int n = 0; n < BLOCK_BEATS; n++) begin
				case ($urandom_range(0, 9)) inside
					[0:4]: a = angle_t'($urandom);
					[5:6]: a = near_half_pi(int'($urandom_range(0, 162)) - 81,
						int'($urandom_range(0, 8)) - 4);
					7: a = angle_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
					8: a = $urandom_range(0, 1) ?
						angle_t'(32'h7FFF_FFFF - $urandom_range(0, 255)) :
						angle_t'(32'h8000_0000 + $urandom_range(0, 255));
					default: begin
						// odd multiple of pi, either sign: a quotient tie
						m = 2 * (2 * int'($urandom_range(0, 19)) + 1);
						if ($urandom_range(0, 1))
							m = -m;
						a = near_half_pi(m, int'($urandom_range(0, 4)) - 2);
					end
				endcase
				send_angle(a);
			end
			// Let the pipeline run dry once in the middle of the run.
			if (b == 2)
				drain_results();
		end

		// Wait out the last results, then a little longer for any stray beat.
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
